/* sv/fp7s_pkg.sv */
// fp7s_pkg: shared types, constants and segment tables for the
// fixed-point to seven-segment block; no dependencies
package fp7s_pkg;

    localparam int VALUE_W    = 17;
    localparam int BCD_DIGITS = 5;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int SEG_W      = 8;

    localparam logic [VALUE_W-1:0] SAT_LIMIT = 17'd100000;
    localparam logic [VALUE_W-1:0] SAT_VALUE = 17'd99900;

    localparam logic [SEG_W-1:0] BLANK_PATTERN = 8'hFF;
    localparam logic [SEG_W-1:0] DOT_DIGIT0    = 8'hEF;
    localparam logic [SEG_W-1:0] DOT_DIGIT1    = 8'hF7;

    typedef logic [3:0]       t_digit;
    typedef logic [SEG_W-1:0] t_seg;

    // leftmost position wiring
    function automatic t_seg seg_left(input t_digit d);
        t_seg s;
        case (d)
            4'd0:    s = 8'h11;
            4'd1:    s = 8'hD7;
            4'd2:    s = 8'h32;
            4'd3:    s = 8'h92;
            4'd4:    s = 8'hD4;
            4'd5:    s = 8'h98;
            4'd6:    s = 8'h18;
            4'd7:    s = 8'hD3;
            4'd8:    s = 8'h10;
            4'd9:    s = 8'h90;
            default: s = BLANK_PATTERN;
        endcase
        return s;
    endfunction

    // middle position wiring
    function automatic t_seg seg_mid(input t_digit d);
        t_seg s;
        case (d)
            4'd0:    s = 8'h88;
            4'd1:    s = 8'hEB;
            4'd2:    s = 8'h4C;
            4'd3:    s = 8'h49;
            4'd4:    s = 8'h2B;
            4'd5:    s = 8'h19;
            4'd6:    s = 8'h18;
            4'd7:    s = 8'hCB;
            4'd8:    s = 8'h08;
            4'd9:    s = 8'h09;
            default: s = BLANK_PATTERN;
        endcase
        return s;
    endfunction

    // rightmost position wiring
    function automatic t_seg seg_right(input t_digit d);
        t_seg s;
        case (d)
            4'd0:    s = 8'h11;
            4'd1:    s = 8'h7D;
            4'd2:    s = 8'h23;
            4'd3:    s = 8'h29;
            4'd4:    s = 8'h4D;
            4'd5:    s = 8'h89;
            4'd6:    s = 8'h81;
            4'd7:    s = 8'h3D;
            4'd8:    s = 8'h01;
            4'd9:    s = 8'h09;
            default: s = BLANK_PATTERN;
        endcase
        return s;
    endfunction

endpackage

/* sv/fp7s_bcd.sv */
// fp7s_bcd: bit-serial binary to bcd converter (shift and add-3)
// depends on fp7s_pkg
module fp7s_bcd (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [fp7s_pkg::VALUE_W-1:0]  i_value,
    output logic                          o_done,
    output logic [fp7s_pkg::BCD_W-1:0]    o_bcd
);

    localparam int CNT_W = $clog2(fp7s_pkg::VALUE_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(fp7s_pkg::VALUE_W - 1);

    logic [fp7s_pkg::VALUE_W-1:0] r_bin;
    logic [fp7s_pkg::BCD_W-1:0]   r_bcd;
    logic [fp7s_pkg::BCD_W-1:0]   n_adj;
    logic [CNT_W-1:0]             r_cnt;
    logic                         r_busy;
    logic                         r_done;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < fp7s_pkg::BCD_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                n_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                n_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bin <= {r_bin[fp7s_pkg::VALUE_W-2:0], 1'b0};
            r_bcd <= {n_adj[fp7s_pkg::BCD_W-2:0], r_bin[fp7s_pkg::VALUE_W-1]};
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without a conversion");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt <= LAST))
        else $error("bit counter past last bit");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("start while converting");

endmodule

/* sv/fixed_point_to_seven_segment.sv */
// fixed_point_to_seven_segment: top level, value in hundredths to three
// active-low seven-segment bytes; depends on fp7s_pkg and fp7s_bcd
//
//  channel  | dir | tdata                          | tuser
//  s_axis   | in  | value_hundredths [16:0]        | display_hold
//  m_axis   | out | digit0/1/2_pattern [7:0..23:16]| -
//
// a word loads the converter at its accept; it shifts in all 17 bits, raises
// done, and the result loads the output register; no new word is taken before
// that load; a word with display_hold set is accepted and gives no result
// the output register holds a result while m_axis_tready is low; the next
// word is accepted meanwhile, and conversion waits only to unload
// synchronous active-low reset clears control state
module fixed_point_to_seven_segment (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // value_hundredths [16:0], zero [23:17]
    input  logic        s_axis_tuser,   // display_hold
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // digit0 [7:0], digit1 [15:8], digit2 [23:16]
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]                      r_state;
    logic [1:0]                      n_state;
    logic                            r_m_valid;
    logic [23:0]                     r_m_data;
    logic                            s_accept;
    logic                            start;
    logic                            load;
    logic [fp7s_pkg::VALUE_W-1:0]    value;
    logic [fp7s_pkg::VALUE_W-1:0]    sat_value;
    logic                            bcd_done;
    logic [fp7s_pkg::BCD_W-1:0]      bcd;
    fp7s_pkg::t_digit                b4, b3, b2, b1, b0;
    fp7s_pkg::t_seg                  p0, p1, p2;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign start         = s_accept && !s_axis_tuser;
    assign value         = s_axis_tdata[fp7s_pkg::VALUE_W-1:0];
    assign sat_value     = (value >= fp7s_pkg::SAT_LIMIT) ? fp7s_pkg::SAT_VALUE : value;
    assign load          = (r_state == ST_WAIT) && (!r_m_valid || m_axis_tready);

    fp7s_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_value (sat_value),
        .o_done  (bcd_done),
        .o_bcd   (bcd)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (bcd_done) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // digit select and dot placement by digit count
    always_comb begin
        b4 = bcd[19:16];
        b3 = bcd[15:12];
        b2 = bcd[11:8];
        b1 = bcd[7:4];
        b0 = bcd[3:0];
        if (b4 != 4'd0) begin
            p0 = fp7s_pkg::seg_left(b4);
            p1 = fp7s_pkg::seg_mid(b3);
            p2 = fp7s_pkg::seg_right(b2);
        end else if (b3 != 4'd0) begin
            p0 = fp7s_pkg::seg_left(b3);
            p1 = fp7s_pkg::seg_mid(b2) & fp7s_pkg::DOT_DIGIT1;
            p2 = fp7s_pkg::seg_right(b1);
        end else if (bcd != '0) begin
            p0 = fp7s_pkg::seg_left(b2) & fp7s_pkg::DOT_DIGIT0;
            p1 = fp7s_pkg::seg_mid(b1);
            p2 = fp7s_pkg::seg_right(b0);
        end else begin
            p0 = fp7s_pkg::BLANK_PATTERN;
            p1 = fp7s_pkg::BLANK_PATTERN;
            p2 = fp7s_pkg::seg_left(4'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_m_data <= {p2, p1, p0};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    a_hold_no_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && s_axis_tuser) |=> (r_state == ST_IDLE))
        else $error("held word started a conversion");

    a_start_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> (r_state == ST_CONV))
        else $error("accepted word not converting");

    a_done_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bcd_done |-> (r_state == ST_CONV))
        else $error("conversion done outside conv state");

    a_result_from_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == ST_WAIT))
        else $error("result raised without a finished conversion");

endmodule

/* test/fixed_point_to_seven_segment_test.sv */
`timescale 1ns / 100ps
// fixed_point_to_seven_segment_test: self-checking bench for the hundredths to
// seven-segment block; corner values, then random words under random stalls
// depends on fp7s_pkg and fixed_point_to_seven_segment
module fixed_point_to_seven_segment_test;

    localparam int LIMIT_CYCLES = 600000;
    localparam int PHASE_WORDS  = 627;
    localparam int STALL_CYCLES = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int VALUE_W      = fp7s_pkg::VALUE_W;

    // segment tables per position, digit 0 in the low byte
    localparam logic [79:0] LEFT_SEGS  = 80'h90_10_D3_18_98_D4_92_32_D7_11;
    localparam logic [79:0] MID_SEGS   = 80'h09_08_CB_18_19_2B_49_4C_EB_88;
    localparam logic [79:0] RIGHT_SEGS = 80'h09_01_3D_81_89_4D_29_23_7D_11;

    typedef struct {
        fp7s_pkg::t_seg digit0;
        fp7s_pkg::t_seg digit1;
        fp7s_pkg::t_seg digit2;
    } t_patterns;

    class segment_board;
        t_patterns patterns_due[$];
        int        mismatches;

        function t_patterns segment_patterns(logic [VALUE_W-1:0] value);
            t_patterns   p;
            int unsigned n;
            int unsigned digits;
            int unsigned scale;
            n = 32'((value >= fp7s_pkg::SAT_LIMIT) ? fp7s_pkg::SAT_VALUE : value);
            digits = (n >= 10000) ? 5 : (n >= 1000) ? 4 : (n >= 100) ? 3 :
                     (n >= 10) ? 2 : (n >= 1) ? 1 : 0;
            p.digit0 = fp7s_pkg::BLANK_PATTERN;
            p.digit1 = fp7s_pkg::BLANK_PATTERN;
            p.digit2 = fp7s_pkg::BLANK_PATTERN;
            if (digits >= 1 && digits <= 3) begin
                p.digit0 = fp7s_pkg::DOT_DIGIT0;
            end else if (digits == 4) begin
                p.digit1 = fp7s_pkg::DOT_DIGIT1;
            end
            if (n == 0) begin
                p.digit2 = LEFT_SEGS[7:0];
            end else begin
                scale = (digits == 5) ? 100 : (digits == 4) ? 10 : 1;
                p.digit0 &= LEFT_SEGS[8 * ((n / (scale * 100)) % 10) +: 8];
                p.digit1 &= MID_SEGS[8 * ((n / (scale * 10)) % 10) +: 8];
                p.digit2 &= RIGHT_SEGS[8 * ((n / scale) % 10) +: 8];
            end
            return p;
        endfunction

        function void note_word(logic [VALUE_W-1:0] value, logic hold);
            if (!hold) begin
                patterns_due.push_back(segment_patterns(value));
            end
        endfunction

        function void compare_field(string name, fp7s_pkg::t_seg want,
                                    fp7s_pkg::t_seg got);
            if (want !== got) begin
                $error("%s: expected %h, got %h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_word(logic [23:0] word);
            t_patterns want;
            if (patterns_due.size() == 0) begin
                $error("result word %h with nothing expected", word);
                mismatches++;
                return;
            end
            want = patterns_due.pop_front();
            compare_field("digit0_pattern", want.digit0, word[7:0]);
            compare_field("digit1_pattern", want.digit1, word[15:8]);
            compare_field("digit2_pattern", want.digit2, word[23:16]);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;    // value_hundredths [16:0], zero [23:17]
    logic        s_axis_tuser = 1'b0;  // display_hold
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // digit0 [7:0], digit1 [15:8], digit2 [23:16]

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_requests = 0;
    int stalls_done = 0;
    int stall_left = 0;
    int cycle_count = 0;

    segment_board board;

    fixed_point_to_seven_segment dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: check, then pick the next ready level
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                board.check_word(m_axis_tdata);
            end
            if (stall_left != 0) begin
                m_axis_tready <= 1'b0;
                stall_left    <= stall_left - 1;
            end else if (stalls_done != stall_requests) begin
                m_axis_tready <= 1'b0;
                stall_left    <= STALL_CYCLES;
                stalls_done   <= stalls_done + 1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // called right after the clock rises; returns right after the word is accepted
    task automatic send_word(input logic [VALUE_W-1:0] value, input logic hold);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(24 - VALUE_W){1'b0}}, value};
        s_axis_tuser  <= hold;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_word(value, hold);
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(7))
            0:       return '0;
            1:       return VALUE_W'($urandom_range(9, 1));
            2:       return VALUE_W'($urandom_range(99, 10));
            3:       return VALUE_W'($urandom_range(999, 100));
            4:       return VALUE_W'($urandom_range(9999, 1000));
            5:       return VALUE_W'($urandom_range(99999, 10000));
            6:       return VALUE_W'($urandom_range(131071, 100000));
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    initial begin
        int unsigned corners[] = '{0, 1, 9, 10, 99, 100, 999, 1000, 1009, 9999,
                                   10000, 10203, 34567, 89999, 99899, 99900,
                                   99999, 100000, 100001, 131071};
        board = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct <= 32;
        recv_idle_pct <= 64;
        foreach (corners[i]) begin
            send_word(VALUE_W'(corners[i]), 1'b0);
        end
        // held words give no result; the unheld word among them does
        send_word(VALUE_W'(131071), 1'b1);
        send_word(VALUE_W'(0), 1'b1);
        send_word(VALUE_W'(5), 1'b0);
        send_word(VALUE_W'(45678), 1'b1);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct <= (ph == 0) ? 32 : (ph == 1) ? 64 : 0;
            recv_idle_pct <= (ph == 0) ? 64 : (ph == 1) ? 32 : 0;
            // long receiver hold-off while words keep coming
            if (ph == 2) begin
                stall_requests <= stall_requests + 1;
            end
            for (int i = 0; i < PHASE_WORDS; i++) begin
                send_word(random_value(), $urandom_range(4) == 0);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (board.patterns_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        foreach (board.patterns_due[i]) begin
            $error("result never arrived: %h %h %h", board.patterns_due[i].digit0,
                   board.patterns_due[i].digit1, board.patterns_due[i].digit2);
        end
        if (board.mismatches == 0 && board.patterns_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/fp7s_pkg.sv
sv/fp7s_bcd.sv
sv/fixed_point_to_seven_segment.sv
test/fixed_point_to_seven_segment_test.sv
